[rtl/srie_pkg.sv]
`default_nettype none

package srie_pkg;

   localparam int DMEM_DEPTH_DEF = 1024;
   localparam int PC_WIDTH_DEF   = 10;
   localparam int REG_COUNT      = 32;
   localparam int RIDX_W         = 5;
   localparam int WORD_W         = 32;
   localparam int OUT_PC_W       = 10;
   localparam int OUT_ADDR_W     = 10;
   localparam int MADDR_FIELD_W  = 21;

   typedef enum logic [5:0] {
      OP_LABEL = 6'h00,
      OP_RTYPE = 6'h01,
      OP_LOAD  = 6'h02,
      OP_STORE = 6'h03,
      OP_JUMP  = 6'h04,
      OP_BEQ   = 6'h05,
      OP_END   = 6'h3F
   } opcode_type;

   localparam logic [5:0] FN_ADD  = 6'd1;
   localparam logic [5:0] FN_ADDI = 6'd2;
   localparam logic [5:0] FN_SUB  = 6'd3;
   localparam logic [5:0] FN_SUBI = 6'd4;

   typedef struct packed {
      logic [OUT_PC_W-1:0]   next_pc;
      logic                  halted;
      logic                  branch_taken;
      logic                  reg_write;
      logic [RIDX_W-1:0]     reg_index;
      logic [WORD_W-1:0]     reg_value;
      logic                  mem_write;
      logic [OUT_ADDR_W-1:0] mem_address;
      logic [WORD_W-1:0]     mem_data;
   } rsp_type;

   typedef struct packed {
      logic              reg_en;
      logic [RIDX_W-1:0] reg_idx;
      logic [WORD_W-1:0] reg_data;
      logic              mem_en;
      logic [WORD_W-1:0] mem_data;
   } wb_type;

endpackage

`default_nettype wire

[rtl/small_risc_instruction_executor_core.sv]
// Channel    | Ports                                   | Moves
// request    | req_valid, req_ready, req_instruction   | one instruction word in
// response   | rsp_valid, rsp_ready, rsp_next_pc ...   | one result per instruction
//
// Throughput one request per cycle while responses are not stalled; rsp_valid rises once a request
// has moved through the address and operand read stages into the response register.
// Stages: address (data memory index), operand read (register file, data memory with write
// forwarding), execute/write back into the response register. After reset the data memory is
// zeroed, one word a cycle, from address 0 to DMEM_DEPTH-1; req_ready stays low until that ends.
// A stalled response holds the pipeline; after the clear, requests stop only when all stages are full.
`default_nettype none

module small_risc_instruction_executor_core #(
   parameter int DMEM_DEPTH = srie_pkg::DMEM_DEPTH_DEF,
   parameter int PC_WIDTH   = srie_pkg::PC_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [31:0]         req_instruction,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [9:0]          rsp_next_pc,
   output logic                rsp_halted,
   output logic                rsp_branch_taken,
   output logic                rsp_reg_write,
   output logic [4:0]          rsp_reg_index,
   output logic signed [31:0]  rsp_reg_value,
   output logic                rsp_mem_write,
   output logic [9:0]          rsp_mem_address,
   output logic signed [31:0]  rsp_mem_data
);

   localparam int DMEM_AW = $clog2(DMEM_DEPTH);
   localparam int XW      = srie_pkg::MADDR_FIELD_W;
   localparam int RECIP   = (1 << XW) / DMEM_DEPTH;
   localparam int QW      = $clog2(RECIP + 1);
   localparam int QPW     = XW + QW;
   localparam logic [XW:0] DEPTH_W = (XW + 1)'(DMEM_DEPTH);
   localparam logic [DMEM_AW-1:0] CLR_LAST = DMEM_AW'(DMEM_DEPTH - 1);
   localparam int RW      = srie_pkg::RIDX_W;
   localparam int WW      = srie_pkg::WORD_W;

   logic                 clearing_ff;
   logic [DMEM_AW-1:0]   clr_cnt_ff;

   logic                 a_valid_ff;
   logic [31:0]          a_instr_ff;
   logic [QW-1:0]        a_q_ff;
   logic [QPW-1:0]       q_prod;
   logic [QW-1:0]        a_q_in;
   logic [XW:0]          a_qd;
   logic [XW:0]          a_rem;
   logic [XW:0]          a_rem_fix;
   logic [DMEM_AW-1:0]   a_addr;
   logic [RW-1:0]        a_rs;
   logic [RW-1:0]        a_rb;

   logic                 b_valid_ff;
   logic [31:0]          b_instr_ff;
   logic [DMEM_AW-1:0]   b_addr_ff;
   logic                 fa_hit_ff;
   logic                 fb_hit_ff;
   logic                 fm_hit_ff;
   logic [WW-1:0]        fa_data_ff;
   logic [WW-1:0]        fb_data_ff;
   logic [WW-1:0]        fm_data_ff;
   logic                 va_ff;
   logic                 vb_ff;
   logic [srie_pkg::REG_COUNT-1:0] rf_vld_ff;

   logic [WW-1:0]        rfa_q;
   logic [WW-1:0]        rfb_q;
   logic [WW-1:0]        dm_q;
   logic [WW-1:0]        op_a;
   logic [WW-1:0]        op_b;
   logic [WW-1:0]        mem_q;

   logic [PC_WIDTH-1:0]  pc_ff;
   logic                 halt_ff;
   srie_pkg::rsp_type    ex_rsp;
   srie_pkg::wb_type     ex_wb;
   logic [PC_WIDTH-1:0]  ex_pc;
   logic                 ex_halt;

   logic                 o_valid_ff;
   srie_pkg::rsp_type    o_ff;

   logic                 a_go;
   logic                 b_go;
   logic                 rf_we;
   logic                 dm_we;
   logic [DMEM_AW-1:0]   dm_waddr;
   logic [WW-1:0]        dm_wdata;

   assign b_go      = b_valid_ff && (!o_valid_ff || rsp_ready);
   assign a_go      = a_valid_ff && (!b_valid_ff || b_go);
   assign req_ready = !clearing_ff && (!a_valid_ff || a_go);

   // data memory index: low address field modulo depth, by reciprocal
   assign q_prod    = QPW'(req_instruction[XW-1:0]) * QPW'(RECIP);
   assign a_q_in    = q_prod[QPW-1:XW];
   assign a_qd      = (XW + 1)'(a_q_ff) * DEPTH_W;
   assign a_rem     = {1'b0, a_instr_ff[XW-1:0]} - a_qd;
   assign a_rem_fix = (a_rem >= DEPTH_W) ? a_rem - DEPTH_W : a_rem;
   assign a_addr    = a_rem_fix[DMEM_AW-1:0];

   assign a_rs = a_instr_ff[20:16];
   assign a_rb = (a_instr_ff[31:26] == srie_pkg::OP_RTYPE) ? a_instr_ff[10:6]
                                                          : a_instr_ff[25:21];

   assign rf_we    = b_go && ex_wb.reg_en;
   assign dm_we    = clearing_ff || (b_go && ex_wb.mem_en);
   assign dm_waddr = clearing_ff ? clr_cnt_ff : b_addr_ff;
   assign dm_wdata = clearing_ff ? '0 : ex_wb.mem_data;

   srie_ram #(.WIDTH(WW), .DEPTH(srie_pkg::REG_COUNT)) u_rf_a (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (ex_wb.reg_idx),
      .wr_data (ex_wb.reg_data),
      .rd_en   (a_go),
      .rd_addr (a_rs),
      .rd_q    (rfa_q)
   );

   srie_ram #(.WIDTH(WW), .DEPTH(srie_pkg::REG_COUNT)) u_rf_b (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (ex_wb.reg_idx),
      .wr_data (ex_wb.reg_data),
      .rd_en   (a_go),
      .rd_addr (a_rb),
      .rd_q    (rfb_q)
   );

   srie_ram #(.WIDTH(WW), .DEPTH(DMEM_DEPTH)) u_dmem (
      .clock   (clock),
      .wr_en   (dm_we),
      .wr_addr (dm_waddr),
      .wr_data (dm_wdata),
      .rd_en   (a_go),
      .rd_addr (a_addr),
      .rd_q    (dm_q)
   );

   assign op_a  = fa_hit_ff ? fa_data_ff : (va_ff ? rfa_q : '0);
   assign op_b  = fb_hit_ff ? fb_data_ff : (vb_ff ? rfb_q : '0);
   assign mem_q = fm_hit_ff ? fm_data_ff : dm_q;

   srie_exec #(.PC_WIDTH(PC_WIDTH), .DMEM_AW(DMEM_AW)) u_exec (
      .instr     (b_instr_ff),
      .op_a      (op_a),
      .op_b      (op_b),
      .mem_q     (mem_q),
      .addr      (b_addr_ff),
      .pc        (pc_ff),
      .halted    (halt_ff),
      .rsp       (ex_rsp),
      .wb        (ex_wb),
      .pc_next   (ex_pc),
      .halt_next (ex_halt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
         a_valid_ff  <= 1'b0;
         b_valid_ff  <= 1'b0;
         o_valid_ff  <= 1'b0;
         rf_vld_ff   <= '0;
         pc_ff       <= '0;
         halt_ff     <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_cnt_ff <= clr_cnt_ff + DMEM_AW'(1);
            if (clr_cnt_ff == CLR_LAST) begin
               clearing_ff <= 1'b0;
            end
         end
         if (req_valid && req_ready) begin
            a_valid_ff <= 1'b1;
         end else if (a_go) begin
            a_valid_ff <= 1'b0;
         end
         if (a_go) begin
            b_valid_ff <= 1'b1;
         end else if (b_go) begin
            b_valid_ff <= 1'b0;
         end
         if (b_go) begin
            o_valid_ff <= 1'b1;
            pc_ff      <= ex_pc;
            halt_ff    <= ex_halt;
         end else if (rsp_ready) begin
            o_valid_ff <= 1'b0;
         end
         if (rf_we) begin
            rf_vld_ff[ex_wb.reg_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         a_instr_ff <= req_instruction;
         a_q_ff     <= a_q_in;
      end
      if (a_go) begin
         b_instr_ff <= a_instr_ff;
         b_addr_ff  <= a_addr;
         va_ff      <= rf_vld_ff[a_rs];
         vb_ff      <= rf_vld_ff[a_rb];
         fa_hit_ff  <= rf_we && (ex_wb.reg_idx == a_rs);
         fb_hit_ff  <= rf_we && (ex_wb.reg_idx == a_rb);
         fm_hit_ff  <= b_go && ex_wb.mem_en && (b_addr_ff == a_addr);
         fa_data_ff <= ex_wb.reg_data;
         fb_data_ff <= ex_wb.reg_data;
         fm_data_ff <= ex_wb.mem_data;
      end
      if (b_go) begin
         o_ff <= ex_rsp;
      end
   end

   assign rsp_valid        = o_valid_ff;
   assign rsp_next_pc      = o_ff.next_pc;
   assign rsp_halted       = o_ff.halted;
   assign rsp_branch_taken = o_ff.branch_taken;
   assign rsp_reg_write    = o_ff.reg_write;
   assign rsp_reg_index    = o_ff.reg_index;
   assign rsp_reg_value    = $signed(o_ff.reg_value);
   assign rsp_mem_write    = o_ff.mem_write;
   assign rsp_mem_address  = o_ff.mem_address;
   assign rsp_mem_data     = $signed(o_ff.mem_data);

   a_no_req_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !req_ready)
      else $error("request taken during memory clear");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halt flag dropped");

   a_halted_no_writes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_halted) |-> (!rsp_reg_write && !rsp_mem_write))
      else $error("write reported while halted");

   a_exec_holds: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !b_go) |=> (b_valid_ff && $stable(b_instr_ff)))
      else $error("execute stage lost its request");

endmodule

`default_nettype wire

[rtl/srie_ram.sv]
`default_nettype none

module srie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_q
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[rtl/srie_exec.sv]
`default_nettype none

module srie_exec #(
   parameter int PC_WIDTH = srie_pkg::PC_WIDTH_DEF,
   parameter int DMEM_AW  = 10
) (
   input  logic [31:0]                  instr,
   input  logic [srie_pkg::WORD_W-1:0]  op_a,
   input  logic [srie_pkg::WORD_W-1:0]  op_b,
   input  logic [srie_pkg::WORD_W-1:0]  mem_q,
   input  logic [DMEM_AW-1:0]           addr,
   input  logic [PC_WIDTH-1:0]          pc,
   input  logic                         halted,
   output srie_pkg::rsp_type            rsp,
   output srie_pkg::wb_type             wb,
   output logic [PC_WIDTH-1:0]          pc_next,
   output logic                         halt_next
);

   logic [srie_pkg::WORD_W-1:0]  prod;
   logic [srie_pkg::WORD_W-1:0]  alu;
   logic [PC_WIDTH-1:0]          pc_inc;
   logic [PC_WIDTH-1:0]          target;
   logic [srie_pkg::WORD_W-1:0]  imm;
   srie_pkg::opcode_type         op;
   logic                         taken;
   logic                         addr_used;

   assign prod   = op_a * op_b;
   assign pc_inc = pc + PC_WIDTH'(1);
   assign target = instr[PC_WIDTH-1:0];
   assign imm    = {22'd0, instr[15:6]};
   assign op     = srie_pkg::opcode_type'(instr[31:26]);

   always_comb begin
      unique case (instr[5:0])
         srie_pkg::FN_ADD:  alu = op_a + op_b;
         srie_pkg::FN_ADDI: alu = op_a + imm;
         srie_pkg::FN_SUB:  alu = op_a - op_b;
         srie_pkg::FN_SUBI: alu = op_a - imm;
         default:           alu = prod;
      endcase
   end

   always_comb begin
      pc_next   = pc_inc;
      halt_next = halted;
      taken     = 1'b0;
      addr_used = 1'b0;
      wb        = '0;
      if (halted) begin
         pc_next = pc;
      end else begin
         unique case (op)
            srie_pkg::OP_RTYPE: begin
               wb.reg_en   = 1'b1;
               wb.reg_idx  = instr[25:21];
               wb.reg_data = alu;
            end
            srie_pkg::OP_LOAD: begin
               wb.reg_en   = 1'b1;
               wb.reg_idx  = instr[25:21];
               wb.reg_data = mem_q;
               addr_used   = 1'b1;
            end
            srie_pkg::OP_STORE: begin
               wb.mem_en   = 1'b1;
               wb.mem_data = op_b;
               addr_used   = 1'b1;
            end
            srie_pkg::OP_JUMP: begin
               pc_next = target;
               taken   = 1'b1;
            end
            srie_pkg::OP_BEQ: begin
               if (op_a == op_b) begin
                  pc_next = target;
                  taken   = 1'b1;
               end
            end
            srie_pkg::OP_END: begin
               halt_next = 1'b1;
               pc_next   = pc;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp.next_pc      = srie_pkg::OUT_PC_W'(pc_next);
      rsp.halted       = halt_next;
      rsp.branch_taken = taken;
      rsp.reg_write    = wb.reg_en;
      rsp.reg_index    = wb.reg_idx;
      rsp.reg_value    = wb.reg_data;
      rsp.mem_write    = wb.mem_en;
      rsp.mem_address  = addr_used ? srie_pkg::OUT_ADDR_W'(addr) : '0;
      rsp.mem_data     = wb.mem_data;
   end

endmodule

`default_nettype wire
